>>> src/adlr_pkg.sv
package adlr_pkg;

   localparam int COORD_W         = 16;
   localparam int POS_EXTRA_BITS  = 14;
   localparam int SQRT_EXTRA_BITS = 12;
   localparam int CELL_W          = 20;
   localparam int CELL_FRAC_BITS  = 12;
   localparam int STEP_W          = 11;
   localparam int POS_W           = 32;
   localparam int DELTA_W         = COORD_W + 1;
   localparam int DIST2_W         = 2 * DELTA_W + 1;
   localparam int ROOT_IN_W       = 60;
   localparam int ROOT_W          = ROOT_IN_W / 2;
   localparam int CFG_COLS_W      = 8;
   localparam int CFG_ROWS_W      = 7;

   localparam logic [CELL_W-1:0] CELL_MAX = '1;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;

   // register index, taken from paddr[2]
   localparam logic REG_COLS = 1'b0;
   localparam logic REG_ROWS = 1'b1;

   typedef enum logic [1:0] {
      CMD_DOT,
      CMD_LINE,
      CMD_READ,
      CMD_CLEAR
   } cmd_type;

   typedef enum logic [1:0] {
      CV_ADD,
      CV_READ,
      CV_CLEAR
   } cv_op_type;

   typedef struct packed {
      logic      valid;
      cv_op_type op;
   } cv_cmd_type;

   typedef struct packed {
      logic ready;
      logic rd_valid;
   } cv_stat_type;

endpackage

>>> src/antialiased_dot_line_raster_core.sv
// Antialiased dot and line rasterizer on a canvas of MAX_ROWS x MAX_COLS Q8.12 cells kept in one
// single-port synchronous memory. Every command returns one word. A dot makes up to four
// saturating read-modify-write cell updates through the memory port, one per corner on the canvas.
// A line first runs a bit-serial square root and two bit-serial divisions for the unit step, then
// makes one dot per step. Clear sweeps the memory one cell per cycle over all
// 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells (8192 by default); the same sweep runs after reset,
// and req_stall stays high until it ends. Configuration writes are taken at any time.
module antialiased_dot_line_raster_core #(
   parameter int MAX_COLS        = 128,
   parameter int MAX_ROWS        = 64,
   parameter int COORD_FRAC_BITS = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic [6:0]         req_cell_col,
   input  logic [5:0]         req_cell_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_cell_value,
   output logic [10:0]        rsp_dots_drawn,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int ADDR_W    = COL_W + ROW_W;
   localparam int P         = COORD_FRAC_BITS + adlr_pkg::POS_EXTRA_BITS;
   localparam int POS_W     = adlr_pkg::POS_W;
   localparam int WGT_W     = P + 1;
   localparam int PROD_W    = 2 * WGT_W;
   localparam int SPLAT_SH  = 2 * P - adlr_pkg::CELL_FRAC_BITS;
   localparam int DIV_SH    = P + adlr_pkg::SQRT_EXTRA_BITS;
   localparam int DIV_NW    = adlr_pkg::DELTA_W + DIV_SH + 1;
   localparam int NS_W      = adlr_pkg::ROOT_W - adlr_pkg::SQRT_EXTRA_BITS + 2;
   localparam int SIGN_EXT  = POS_W - adlr_pkg::COORD_W - adlr_pkg::POS_EXTRA_BITS;
   localparam int DW        = adlr_pkg::DELTA_W;
   localparam int CW        = adlr_pkg::CELL_W;
   localparam int SW        = adlr_pkg::STEP_W;

   localparam logic [POS_W-1:0]  HALF_PIX = POS_W'(1) << (P - 1);
   localparam logic [WGT_W-1:0]  ONE_PIX  = WGT_W'(1) << P;
   localparam logic [PROD_W:0]   W_ROUND  = (PROD_W + 1)'(1) << (SPLAT_SH - 1);
   localparam logic [NS_W-1:0]   N_ROUND  = NS_W'(1) << COORD_FRAC_BITS;

   typedef enum logic [3:0] {
      T_IDLE,
      T_SQUARE,
      T_ROOT_GO,
      T_ROOT_WAIT,
      T_DIVX_GO,
      T_DIVX_WAIT,
      T_DIVY_GO,
      T_DIVY_WAIT,
      T_MUL,
      T_ISSUE,
      T_READ_GO,
      T_READ_WAIT,
      T_CLEAR_GO,
      T_DONE
   } state_type;

   state_type                 state_ff;
   logic signed [DW-1:0]      dx_ff;
   logic signed [DW-1:0]      dy_ff;
   logic [adlr_pkg::DIST2_W-1:0] d2_ff;
   logic [adlr_pkg::ROOT_W-1:0]  root_ff;
   logic [POS_W-1:0]          pos_x_ff;
   logic [POS_W-1:0]          pos_y_ff;
   logic [POS_W-1:0]          step_x_ff;
   logic [POS_W-1:0]          step_y_ff;
   logic [SW-1:0]             steps_ff;
   logic [1:0]                corner_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [ADDR_W-1:0]         cell_addr_ff;
   logic                      hit_ff;
   logic [SW-1:0]             dots_ff;
   logic [CW-1:0]             value_ff;
   logic                      rsp_valid_ff;
   logic [CW-1:0]             rsp_cell_value_ff;
   logic [SW-1:0]             rsp_dots_drawn_ff;
   logic [adlr_pkg::CFG_COLS_W-1:0] cfg_cols_ff;
   logic [adlr_pkg::CFG_ROWS_W-1:0] cfg_rows_ff;

   logic [31:0]               eff_cols;
   logic [31:0]               eff_rows;
   logic                      req_take;
   logic                      rd_hit;

   logic signed [POS_W-1:0]   bx;
   logic signed [POS_W-1:0]   by;
   logic signed [POS_W-1:0]   cell_x;
   logic signed [POS_W-1:0]   cell_y;
   logic [POS_W-1:0]          col_w;
   logic [POS_W-1:0]          row_w;
   logic [WGT_W-1:0]          wx;
   logic [WGT_W-1:0]          wy;
   logic                      corner_hit;
   logic [PROD_W:0]           wsum;
   logic [CW-1:0]             weight;

   logic signed [2*DW-1:0]    sqx;
   logic signed [2*DW-1:0]    sqy;
   logic [adlr_pkg::ROOT_IN_W-1:0] root_in;
   logic                      root_done;
   logic [adlr_pkg::ROOT_W-1:0]    root_out;
   logic [NS_W-1:0]           n_sum;
   logic [NS_W-1:0]           n_raw;
   logic [SW-1:0]             n_steps;

   logic signed [DW-1:0]      div_delta;
   logic [DW-1:0]             div_abs;
   logic [DIV_NW-1:0]         div_num;
   logic                      div_start;
   logic                      div_done;
   logic [DIV_NW-1:0]         div_quot;
   logic [POS_W-1:0]          div_mag;
   logic [POS_W-1:0]          div_step;

   adlr_pkg::cv_cmd_type      cv_cmd;
   adlr_pkg::cv_stat_type     cv_stat;
   logic [CW-1:0]             cv_rd_data;

   assign eff_cols = (32'(cfg_cols_ff) < 32'(MAX_COLS)) ? 32'(cfg_cols_ff) : 32'(MAX_COLS);
   assign eff_rows = (32'(cfg_rows_ff) < 32'(MAX_ROWS)) ? 32'(cfg_rows_ff) : 32'(MAX_ROWS);

   assign req_stall = (state_ff != T_IDLE) || !cv_stat.ready;
   assign req_take  = req_valid && !req_stall;
   assign rd_hit    = (32'(req_cell_col) < eff_cols) && (32'(req_cell_row) < eff_rows);

   // splat corner: bit 0 picks the right column, bit 1 the lower row
   assign bx     = pos_x_ff - HALF_PIX;
   assign by     = pos_y_ff - HALF_PIX;
   assign cell_x = bx >>> P;
   assign cell_y = by >>> P;
   assign col_w  = cell_x + POS_W'(corner_ff[0]);
   assign row_w  = cell_y + POS_W'(corner_ff[1]);
   assign wx    = corner_ff[0] ? {1'b0, bx[P-1:0]} : ONE_PIX - {1'b0, bx[P-1:0]};
   assign wy    = corner_ff[1] ? {1'b0, by[P-1:0]} : ONE_PIX - {1'b0, by[P-1:0]};
   assign corner_hit = !col_w[POS_W-1] && !row_w[POS_W-1]
                       && (col_w < eff_cols) && (row_w < eff_rows);
   assign wsum   = {1'b0, prod_ff} + W_ROUND;
   assign weight = wsum[SPLAT_SH +: CW];

   // line length
   assign sqx     = dx_ff * dx_ff;
   assign sqy     = dy_ff * dy_ff;
   assign root_in = adlr_pkg::ROOT_IN_W'(d2_ff) << (2 * adlr_pkg::SQRT_EXTRA_BITS);
   assign n_sum   = NS_W'(root_out >> (adlr_pkg::SQRT_EXTRA_BITS - 1)) + N_ROUND;
   assign n_raw   = n_sum >> (COORD_FRAC_BITS + 1);
   assign n_steps = (n_raw > NS_W'(adlr_pkg::STEP_MAX)) ? adlr_pkg::STEP_MAX : n_raw[SW-1:0];

   // unit step, rounded half away from zero
   assign div_delta = (state_ff == T_DIVY_GO || state_ff == T_DIVY_WAIT) ? dy_ff : dx_ff;
   assign div_abs   = div_delta[DW-1] ? DW'(-div_delta) : div_delta;
   assign div_num   = (DIV_NW'(div_abs) << DIV_SH) + DIV_NW'(root_ff >> 1);
   assign div_start = (state_ff == T_DIVX_GO) || (state_ff == T_DIVY_GO);
   assign div_mag   = div_quot[POS_W-1:0];
   assign div_step  = div_delta[DW-1] ? (~div_mag + 1'b1) : div_mag;

   always_comb begin
      cv_cmd.valid = 1'b0;
      cv_cmd.op    = adlr_pkg::CV_ADD;
      case (state_ff)
         T_ISSUE: begin
            cv_cmd.valid = hit_ff;
         end
         T_READ_GO: begin
            cv_cmd.valid = 1'b1;
            cv_cmd.op    = adlr_pkg::CV_READ;
         end
         T_CLEAR_GO: begin
            cv_cmd.valid = 1'b1;
            cv_cmd.op    = adlr_pkg::CV_CLEAR;
         end
         default: ;
      endcase
   end

   adlr_isqrt #(
      .IN_W(adlr_pkg::ROOT_IN_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == T_ROOT_GO),
      .radicand (root_in),
      .done     (root_done),
      .root     (root_out)
   );

   adlr_div #(
      .NUM_W(DIV_NW),
      .DEN_W(adlr_pkg::ROOT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (root_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   adlr_canvas #(
      .ADDR_W(ADDR_W)
   ) u_canvas (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cv_cmd),
      .addr    (cell_addr_ff),
      .weight  (weight),
      .stat    (cv_stat),
      .rd_data (cv_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_cols_ff  <= adlr_pkg::CFG_COLS_W'(128);
         cfg_rows_ff  <= adlr_pkg::CFG_ROWS_W'(64);
      end else begin
         if (psel && penable && pwrite) begin
            case (paddr[2])
               adlr_pkg::REG_COLS: cfg_cols_ff <= pwdata[adlr_pkg::CFG_COLS_W-1:0];
               adlr_pkg::REG_ROWS: cfg_rows_ff <= pwdata[adlr_pkg::CFG_ROWS_W-1:0];
               default: ;
            endcase
         end

         // the done state loads the next word itself
         if (rsp_valid_ff && !rsp_stall && state_ff != T_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            T_IDLE: begin
               if (req_take) begin
                  value_ff <= '0;
                  pos_x_ff <= {{SIGN_EXT{req_start_x[15]}}, req_start_x,
                               {adlr_pkg::POS_EXTRA_BITS{1'b0}}};
                  pos_y_ff <= {{SIGN_EXT{req_start_y[15]}}, req_start_y,
                               {adlr_pkg::POS_EXTRA_BITS{1'b0}}};
                  dx_ff    <= {req_end_x[15], req_end_x} - {req_start_x[15], req_start_x};
                  dy_ff    <= {req_end_y[15], req_end_y} - {req_start_y[15], req_start_y};
                  corner_ff    <= '0;
                  cell_addr_ff <= {ROW_W'(req_cell_row), COL_W'(req_cell_col)};
                  case (adlr_pkg::cmd_type'(req_command))
                     adlr_pkg::CMD_DOT: begin
                        steps_ff <= SW'(1);
                        dots_ff  <= SW'(1);
                        state_ff <= T_MUL;
                     end
                     adlr_pkg::CMD_LINE: state_ff <= T_SQUARE;
                     adlr_pkg::CMD_READ: begin
                        dots_ff  <= '0;
                        state_ff <= rd_hit ? T_READ_GO : T_DONE;
                     end
                     adlr_pkg::CMD_CLEAR: begin
                        dots_ff  <= '0;
                        state_ff <= T_CLEAR_GO;
                     end
                     default: begin
                        dots_ff  <= '0;
                        state_ff <= T_DONE;
                     end
                  endcase
               end
            end
            T_SQUARE: begin
               d2_ff    <= adlr_pkg::DIST2_W'(unsigned'(sqx))
                           + adlr_pkg::DIST2_W'(unsigned'(sqy));
               state_ff <= T_ROOT_GO;
            end
            T_ROOT_GO: state_ff <= T_ROOT_WAIT;
            T_ROOT_WAIT: begin
               if (root_done) begin
                  root_ff  <= root_out;
                  steps_ff <= n_steps;
                  dots_ff  <= n_steps;
                  state_ff <= (n_steps == '0) ? T_DONE : T_DIVX_GO;
               end
            end
            T_DIVX_GO: state_ff <= T_DIVX_WAIT;
            T_DIVX_WAIT: begin
               if (div_done) begin
                  step_x_ff <= div_step;
                  state_ff  <= T_DIVY_GO;
               end
            end
            T_DIVY_GO: state_ff <= T_DIVY_WAIT;
            T_DIVY_WAIT: begin
               if (div_done) begin
                  step_y_ff <= div_step;
                  state_ff  <= T_MUL;
               end
            end
            T_MUL: begin
               prod_ff      <= wx * wy;
               hit_ff       <= corner_hit;
               cell_addr_ff <= {row_w[ROW_W-1:0], col_w[COL_W-1:0]};
               state_ff     <= T_ISSUE;
            end
            T_ISSUE: begin
               // off-canvas corners are skipped without touching memory
               if (!hit_ff || cv_stat.ready) begin
                  corner_ff <= corner_ff + 1'b1;
                  state_ff  <= T_MUL;
                  if (corner_ff == 2'd3) begin
                     steps_ff <= steps_ff - 1'b1;
                     pos_x_ff <= pos_x_ff + step_x_ff;
                     pos_y_ff <= pos_y_ff + step_y_ff;
                     if (steps_ff == SW'(1)) begin
                        state_ff <= T_DONE;
                     end
                  end
               end
            end
            T_READ_GO: begin
               if (cv_stat.ready) begin
                  state_ff <= T_READ_WAIT;
               end
            end
            T_READ_WAIT: begin
               if (cv_stat.rd_valid) begin
                  value_ff <= cv_rd_data;
                  state_ff <= T_DONE;
               end
            end
            T_CLEAR_GO: begin
               if (cv_stat.ready) begin
                  state_ff <= T_DONE;
               end
            end
            T_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_cell_value_ff <= value_ff;
                  rsp_dots_drawn_ff <= dots_ff;
                  state_ff          <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         adlr_pkg::REG_COLS: prdata = 32'(cfg_cols_ff);
         adlr_pkg::REG_ROWS: prdata = 32'(cfg_rows_ff);
         default:            prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_value_ff;
   assign rsp_dots_drawn = rsp_dots_drawn_ff;

endmodule

>>> src/adlr_isqrt.sv
module adlr_isqrt #(
   parameter int IN_W = 60
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IN_W-1:0]     radicand,
   output logic                done,
   output logic [IN_W/2-1:0]   root
);

   localparam int RT_W  = IN_W / 2;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [IN_W-1:0]   rad_ff;
   logic [RT_W+1:0]   rem_ff;
   logic [RT_W-1:0]   root_ff;
   logic [RT_W+1:0]   rem_sh;
   logic [RT_W+1:0]   trial;
   logic              ge;

   // two radicand bits enter the partial remainder per step
   assign rem_sh = {rem_ff[RT_W-1:0], rad_ff[IN_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (run_ff) begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff <= {root_ff[RT_W-2:0], ge};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RT_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> src/adlr_div.sv
module adlr_div #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  denom,
   output logic              done,
   output logic [NUM_W-1:0]  quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NUM_W-1:0]  quot_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W:0]    rem_sh;
   logic              ge;

   // restoring long division, one quotient bit per cycle
   assign rem_sh = {rem_ff, quot_ff[NUM_W-1]};
   assign ge     = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            quot_ff <= numer;
            den_ff  <= denom;
            rem_ff  <= '0;
         end else if (run_ff) begin
            rem_ff  <= ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            quot_ff <= {quot_ff[NUM_W-2:0], ge};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> src/adlr_canvas.sv
module adlr_canvas #(
   parameter int ADDR_W = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  adlr_pkg::cv_cmd_type        cmd,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [adlr_pkg::CELL_W-1:0] weight,
   output adlr_pkg::cv_stat_type       stat,
   output logic [adlr_pkg::CELL_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RMW,
      S_RD,
      S_CLR
   } state_type;

   state_type                     state_ff;
   logic [ADDR_W-1:0]             addr_ff;
   logic [ADDR_W-1:0]             clr_ff;
   logic [adlr_pkg::CELL_W-1:0]   w_ff;
   logic [adlr_pkg::CELL_W-1:0]   rd_data_ff;
   logic [adlr_pkg::CELL_W-1:0]   cells_mem [DEPTH];

   logic                          mem_we;
   logic                          mem_re;
   logic [ADDR_W-1:0]             mem_waddr;
   logic [adlr_pkg::CELL_W-1:0]   mem_wdata;
   logic [adlr_pkg::CELL_W:0]     sum;

   assign sum = {1'b0, rd_data_ff} + {1'b0, w_ff};

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      case (state_ff)
         S_IDLE: begin
            mem_re = cmd.valid && (cmd.op == adlr_pkg::CV_ADD || cmd.op == adlr_pkg::CV_READ);
         end
         S_RMW: begin
            // saturate at full scale
            mem_we    = 1'b1;
            mem_wdata = sum[adlr_pkg::CELL_W] ? adlr_pkg::CELL_MAX
                                              : sum[adlr_pkg::CELL_W-1:0];
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cells_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.valid) begin
                  case (cmd.op)
                     adlr_pkg::CV_ADD: begin
                        addr_ff  <= addr;
                        w_ff     <= weight;
                        state_ff <= S_RMW;
                     end
                     adlr_pkg::CV_READ: begin
                        state_ff <= S_RD;
                     end
                     adlr_pkg::CV_CLEAR: begin
                        clr_ff   <= '0;
                        state_ff <= S_CLR;
                     end
                     default: ;
                  endcase
               end
            end
            S_RMW: state_ff <= S_IDLE;
            S_RD:  state_ff <= S_IDLE;
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign stat.ready    = (state_ff == S_IDLE);
   assign stat.rd_valid = (state_ff == S_RD);
   assign rd_data       = rd_data_ff;

endmodule

>>> test/tb_top.sv
module tb_top;

   localparam int GRID_COLS   = 128;
   localparam int GRID_ROWS   = 64;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [adlr_pkg::CELL_W-1:0] cell_value;
      logic [adlr_pkg::STEP_W-1:0] dots_drawn;
   } raster_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = adlr_pkg::CMD_READ;
   logic signed [15:0] req_start_x = '0;
   logic signed [15:0] req_start_y = '0;
   logic signed [15:0] req_end_x = '0;
   logic signed [15:0] req_end_y = '0;
   logic [6:0]         req_cell_col = '0;
   logic [5:0]         req_cell_row = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [19:0]        rsp_cell_value;
   logic [10:0]        rsp_dots_drawn;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   antialiased_dot_line_raster_core u_top (.*);

   // predictor state
   logic [adlr_pkg::CELL_W-1:0] cell_image [GRID_ROWS*GRID_COLS];
   logic [7:0]        cols_cfg = 8'd128;
   logic [6:0]        rows_cfg = 7'd64;
   raster_word_type   pending_words [$];
   int                errors = 0;
   int                words_sent = 0;
   int                words_checked = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   longint            cycles = 0;

   initial forever #5 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      raster_word_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked <= words_checked + 1;
         if (pending_words.size() == 0) begin
            errors = errors + 1;
            $display("%0t: unexpected word value=%h dots=%0d", $time, rsp_cell_value,
                     rsp_dots_drawn);
         end else begin
            want = pending_words.pop_front();
            if (want.cell_value !== rsp_cell_value) begin
               errors = errors + 1;
               $display("%0t: cell_value expected %h actual %h", $time, want.cell_value,
                        rsp_cell_value);
            end
            if (want.dots_drawn !== rsp_dots_drawn) begin
               errors = errors + 1;
               $display("%0t: dots_drawn expected %0d actual %0d", $time, want.dots_drawn,
                        rsp_dots_drawn);
            end
         end
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int unsigned cols_in_use();
      return (cols_cfg < GRID_COLS) ? cols_cfg : GRID_COLS;
   endfunction

   function automatic int unsigned rows_in_use();
      return (rows_cfg < GRID_ROWS) ? rows_cfg : GRID_ROWS;
   endfunction

   function automatic void add_weight(longint col, longint row, longint unsigned wa,
                                      longint unsigned wb);
      longint unsigned w;
      longint unsigned sum;
      int idx;
      if (col < 0 || row < 0) return;
      if (col >= cols_in_use() || row >= rows_in_use()) return;
      w = (wa * wb + (64'd1 << 27)) >> 28;
      idx = int'(row) * GRID_COLS + int'(col);
      sum = cell_image[idx] + w;
      cell_image[idx] = (sum > adlr_pkg::CELL_MAX) ? adlr_pkg::CELL_MAX
                                                   : sum[adlr_pkg::CELL_W-1:0];
   endfunction

   // x, y carry 20 fraction bits
   function automatic void splat_dot(longint x, longint y);
      longint bx, by, cx, cy;
      longint unsigned fx, fy, lx, ty;
      bx = x - (64'sd1 <<< 19);
      by = y - (64'sd1 <<< 19);
      cx = bx >>> 20;
      cy = by >>> 20;
      fx = bx & 64'hFFFFF;
      fy = by & 64'hFFFFF;
      lx = (64'd1 << 20) - fx;
      ty = (64'd1 << 20) - fy;
      add_weight(cx, cy, lx, ty);
      add_weight(cx + 1, cy, fx, ty);
      add_weight(cx, cy + 1, lx, fy);
      add_weight(cx + 1, cy + 1, fx, fy);
   endfunction

   function automatic longint unit_step(longint d, longint unsigned r);
      longint unsigned mag, q;
      mag = longint'(d < 0 ? -d : d) << 32;
      q = (mag + r / 2) / r;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [adlr_pkg::STEP_W-1:0] walk_line(longint x1, longint y1,
                                                            longint x2, longint y2);
      longint dx, dy, px, py, sx, sy;
      longint unsigned d2, n, r;
      dx = x2 - x1;
      dy = y2 - y1;
      d2 = dx * dx + dy * dy;
      n = (int_sqrt(4 * d2) + 64) >> 7;
      if (n > adlr_pkg::STEP_MAX) n = adlr_pkg::STEP_MAX;
      if (n == 0) return '0;
      r = int_sqrt(d2 << 24);
      if (r == 0) r = 1;
      sx = unit_step(dx, r);
      sy = unit_step(dy, r);
      px = x1 * 16384;
      py = y1 * 16384;
      for (longint unsigned i = 0; i < n; i++) begin
         splat_dot(px, py);
         px += sx;
         py += sy;
      end
      return n[adlr_pkg::STEP_W-1:0];
   endfunction

   function automatic raster_word_type predict_word(logic [1:0] cmd, logic signed [15:0] sx,
      logic signed [15:0] sy, logic signed [15:0] ex, logic signed [15:0] ey,
      logic [6:0] col, logic [5:0] row);
      raster_word_type w;
      w = '0;
      case (cmd)
         adlr_pkg::CMD_DOT: begin
            splat_dot(longint'(sx) * 16384, longint'(sy) * 16384);
            w.dots_drawn = adlr_pkg::STEP_W'(1);
         end
         adlr_pkg::CMD_LINE: begin
            w.dots_drawn = walk_line(longint'(sx), longint'(sy), longint'(ex), longint'(ey));
         end
         adlr_pkg::CMD_READ: begin
            if (col < cols_in_use() && row < rows_in_use())
               w.cell_value = cell_image[int'(row) * GRID_COLS + int'(col)];
         end
         default: begin
            foreach (cell_image[i]) cell_image[i] = '0;
         end
      endcase
      return w;
   endfunction

   task automatic send_word(logic [1:0] cmd, logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] ex, logic signed [15:0] ey,
                            logic [6:0] col, logic [5:0] row);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_start_x  <= sx;
      req_start_y  <= sy;
      req_end_x    <= ex;
      req_end_y    <= ey;
      req_cell_col <= col;
      req_cell_row <= row;
      do @(posedge clock); while (req_stall);
      pending_words = {pending_words, predict_word(cmd, sx, sy, ex, ey, col, row)};
      words_sent++;
   endtask

   task automatic send_dot(int x, int y);
      send_word(adlr_pkg::CMD_DOT, x[15:0], y[15:0], 16'($urandom), 16'($urandom),
                7'($urandom), 6'($urandom));
   endtask

   task automatic send_line(int x1, int y1, int x2, int y2);
      send_word(adlr_pkg::CMD_LINE, x1[15:0], y1[15:0], x2[15:0], y2[15:0], 7'($urandom),
                6'($urandom));
   endtask

   task automatic send_read(int col, int row);
      send_word(adlr_pkg::CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), col[6:0], row[5:0]);
   endtask

   task automatic send_clear();
      send_word(adlr_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 7'($urandom), 6'($urandom));
   endtask

   // also waits out a clear sweep still running in the canvas
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0 || req_stall) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'($urandom_range(0, 32'hFFFFFF)), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == adlr_pkg::REG_COLS) cols_cfg = value;
      else rows_cfg = value[6:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_canvas(int cols, int rows);
      wait_idle();
      write_reg(adlr_pkg::REG_COLS, cols[7:0]);
      write_reg(adlr_pkg::REG_ROWS, rows[7:0]);
   endtask

   // pixel centre in Q10.6
   function automatic int px(int p);
      return p * 64 + 32;
   endfunction

   task automatic test_dots();
      send_dot(px(2), px(3));                // integral splat start, whole weight
      send_read(2, 3);
      send_read(3, 3);
      send_dot(px(5) + 17, px(7) + 45);      // spread over four cells
      send_read(5, 7);
      send_read(6, 8);
      send_dot(32767, 32767);                // off the canvas
      send_dot(-32768, -32768);
      send_dot(0, 0);                        // three of four cells off the canvas
      send_read(0, 0);
      send_dot(px(127) + 40, px(63) + 40);   // right and bottom edge
      send_read(127, 63);
      send_read(127, 0);
   endtask

   task automatic test_lines();
      send_line(px(10), px(10), px(10) + 31, px(10));   // shorter than half a pixel
      send_line(px(10), px(10), px(10) + 32, px(10));   // rounds to one step
      send_line(px(11), px(11), px(11), px(11));         // zero length
      send_line(px(1), px(20), px(30), px(40));
      send_read(15, 30);
      send_line(px(40), px(5), px(33), px(60) + 13);
      send_line(-32768, -32768, 32767, 32767);           // longest line
      send_read(64, 32);
      send_line(32767, -32768, -32768, 32767);
      send_read(60, 3);
   endtask

   task automatic test_saturation();
      for (int i = 0; i < 260; i++) send_dot(px(9), px(9));
      send_read(9, 9);
      send_read(8, 9);
   endtask

   task automatic test_clear();
      send_clear();
      send_read(9, 9);
      send_read(2, 3);
   endtask

   task automatic test_canvas_limits();
      set_canvas(0, 0);                      // nothing in use
      send_dot(px(1), px(1));
      send_line(px(0), px(0), px(20), px(20));
      send_read(1, 1);
      set_canvas(128, 64);
      send_read(1, 1);
      set_canvas(1, 1);
      send_dot(px(0) + 20, px(0) + 20);
      send_read(0, 0);
      send_read(1, 0);
      set_canvas(255, 127);                  // above the maximum acts as the maximum
      send_read(0, 0);
      send_dot(px(127), px(63));
      send_read(127, 63);
   endtask

   task automatic random_word();
      int pick, x1, y1, x2, y2;
      pick = $urandom_range(999);
      x1 = $urandom_range(0, 130 * 64) - 64;
      y1 = $urandom_range(0, 66 * 64) - 64;
      if ($urandom_range(9) == 0) begin
         x1 = $urandom;
         y1 = $urandom;
      end
      if (pick < 4) begin
         send_clear();
      end else if (pick < 450) begin
         send_dot(x1, y1);
      end else if (pick < 650) begin
         if ($urandom_range(99) < 2) begin
            x2 = $urandom;
            y2 = $urandom;
         end else begin
            x2 = x1 + $urandom_range(0, 2560) - 1280;
            y2 = y1 + $urandom_range(0, 2560) - 1280;
            if ($urandom_range(9) == 0) begin
               x2 = x1 + $urandom_range(0, 80) - 40;
               y2 = y1 + $urandom_range(0, 80) - 40;
            end
         end
         send_line(x1, y1, x2, y2);
      end else begin
         send_read($urandom_range(127), $urandom_range(63));
      end
   endtask

   task automatic test_random(int count, int idle, int stall, bit pause_often);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (pause_often && i % 60 == 59) wait_idle();
         random_word();
      end
      wait_idle();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      foreach (cell_image[i]) cell_image[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_dots();
      test_lines();
      test_saturation();
      test_clear();
      test_canvas_limits();
      set_canvas(128, 64);
      test_random(240, 0, 0, 1'b0);
      set_canvas(37, 20);
      test_random(240, 79, 0, 1'b1);
      set_canvas(255, 127);
      test_random(240, 0, 79, 1'b0);
      set_canvas($urandom_range(1, 128), $urandom_range(1, 64));
      test_random(240, 14, 14, 1'b0);
      wait_idle();
      $display("sent %0d words (dots, lines, reads, clears) under four canvas settings,",
               words_sent);
      $display("checked %0d result words with idle and stall phases", words_checked);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/adlr_pkg.sv
src/adlr_isqrt.sv
src/adlr_div.sv
src/adlr_canvas.sv
src/antialiased_dot_line_raster_core.sv
test/tb_top.sv
